@@ rtl/core/ufe_pkg.sv @@
`timescale 1ns / 1ps

package ufe_pkg;

    localparam int ELEM_W        = 10;
    localparam int RANK_W        = 4;
    localparam int NUM_ELEMS_DEF = 1024;

    localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

    localparam logic REQ_FIND  = 1'b0;
    localparam logic REQ_UNION = 1'b1;

    typedef struct packed {
        logic [ELEM_W-1:0] new_root;
        logic              merged;
        logic [ELEM_W-1:0] root_b;
        logic [ELEM_W-1:0] root_a;
    } res_t;

endpackage

@@ rtl/core/ufe_store.sv @@
`timescale 1ns / 1ps

module ufe_store #(
    parameter int NUM_ELEMS = ufe_pkg::NUM_ELEMS_DEF
) (
    input  logic                                                clk,
    input  logic                                                wr_en,
    input  logic [$clog2(NUM_ELEMS)-1:0]                        wr_addr,
    input  logic [$clog2(NUM_ELEMS)+ufe_pkg::RANK_W-1:0]        wr_data,
    input  logic [$clog2(NUM_ELEMS)-1:0]                        rd_addr,
    output logic [$clog2(NUM_ELEMS)+ufe_pkg::RANK_W-1:0]        rd_data
);

    import ufe_pkg::*;

    localparam int IDX_W = $clog2(NUM_ELEMS);
    localparam int ENT_W = IDX_W + RANK_W;

    logic [ENT_W-1:0] mem [NUM_ELEMS];
    logic [ENT_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/ufe_seq.sv @@
`timescale 1ns / 1ps

module ufe_seq #(
    parameter int NUM_ELEMS = ufe_pkg::NUM_ELEMS_DEF
) (
    input  logic                                                clk,
    input  logic                                                rst_n,
    input  logic                                                in_valid,
    output logic                                                in_ready,
    input  logic                                                in_kind,
    input  logic [ufe_pkg::ELEM_W-1:0]                          in_a,
    input  logic [ufe_pkg::ELEM_W-1:0]                          in_b,
    output logic                                                res_valid,
    input  logic                                                res_ready,
    output ufe_pkg::res_t                                       res,
    output logic                                                wr_en,
    output logic [$clog2(NUM_ELEMS)-1:0]                        wr_addr,
    output logic [$clog2(NUM_ELEMS)+ufe_pkg::RANK_W-1:0]        wr_data,
    output logic [$clog2(NUM_ELEMS)-1:0]                        rd_addr,
    input  logic [$clog2(NUM_ELEMS)+ufe_pkg::RANK_W-1:0]        rd_data
);

    import ufe_pkg::*;

    localparam int IDX_W = $clog2(NUM_ELEMS);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ELEMS - 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_WALK  = 3'd2;
    localparam logic [2:0] S_COMP  = 3'd3;
    localparam logic [2:0] S_NEXT  = 3'd4;
    localparam logic [2:0] S_LINK  = 3'd5;
    localparam logic [2:0] S_BUMP  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0]        state_reg,    state_next;
    logic [IDX_W-1:0]  clr_reg,      clr_next;
    logic              kind_reg,     kind_next;
    logic [ELEM_W-1:0] b_reg,        b_next;
    logic              phase_reg,    phase_next;
    logic [IDX_W-1:0]  x_reg,        x_next;
    logic [IDX_W-1:0]  cur_reg,      cur_next;
    logic [IDX_W-1:0]  root_reg,     root_next;
    logic [RANK_W-1:0] rank_reg,     rank_next;
    logic [IDX_W-1:0]  ra_reg,       ra_next;
    logic [RANK_W-1:0] ra_rank_reg,  ra_rank_next;
    logic              ra_ok_reg,    ra_ok_next;
    logic [ELEM_W-1:0] ra_out_reg,   ra_out_next;
    logic [IDX_W-1:0]  rb_reg,       rb_next;
    logic [RANK_W-1:0] rb_rank_reg,  rb_rank_next;
    logic              rb_ok_reg,    rb_ok_next;
    logic [ELEM_W-1:0] rb_out_reg,   rb_out_next;
    logic              merged_reg,   merged_next;
    logic [ELEM_W-1:0] nr_reg,       nr_next;

    logic [IDX_W-1:0]  rd_par;
    logic [RANK_W-1:0] rd_rank;
    logic              a_ok;
    logic              b_ok;
    logic [IDX_W-1:0]  b_idx;
    logic              do_link;

    assign rd_par  = rd_data[IDX_W-1:0];
    assign rd_rank = rd_data[IDX_W +: RANK_W];
    assign a_ok    = 32'(in_a) < 32'(NUM_ELEMS);
    assign b_ok    = 32'(b_reg) < 32'(NUM_ELEMS);
    assign b_idx   = IDX_W'(b_reg);
    assign do_link = (kind_reg == REQ_UNION) && ra_ok_reg && rb_ok_reg && (ra_reg != rb_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        b_reg       <= b_next;
        phase_reg   <= phase_next;
        x_reg       <= x_next;
        cur_reg     <= cur_next;
        root_reg    <= root_next;
        rank_reg    <= rank_next;
        ra_reg      <= ra_next;
        ra_rank_reg <= ra_rank_next;
        ra_ok_reg   <= ra_ok_next;
        ra_out_reg  <= ra_out_next;
        rb_reg      <= rb_next;
        rb_rank_reg <= rb_rank_next;
        rb_ok_reg   <= rb_ok_next;
        rb_out_reg  <= rb_out_next;
        merged_reg  <= merged_next;
        nr_reg      <= nr_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        kind_next    = kind_reg;
        b_next       = b_reg;
        phase_next   = phase_reg;
        x_next       = x_reg;
        cur_next     = cur_reg;
        root_next    = root_reg;
        rank_next    = rank_reg;
        ra_next      = ra_reg;
        ra_rank_next = ra_rank_reg;
        ra_ok_next   = ra_ok_reg;
        ra_out_next  = ra_out_reg;
        rb_next      = rb_reg;
        rb_rank_next = rb_rank_reg;
        rb_ok_next   = rb_ok_reg;
        rb_out_next  = rb_out_reg;
        merged_next  = merged_reg;
        nr_next      = nr_reg;
        rd_addr      = cur_reg;
        wr_en        = 1'b0;
        wr_addr      = cur_reg;
        wr_data      = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_data  = {{RANK_W{1'b0}}, clr_reg};
                clr_next = clr_reg + IDX_W'(1);
                if (clr_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next   = in_kind;
                    b_next      = in_b;
                    phase_next  = 1'b0;
                    ra_ok_next  = 1'b0;
                    ra_out_next = in_a;
                    rb_ok_next  = 1'b0;
                    rb_out_next = '0;
                    if (a_ok)
                    begin
                        rd_addr    = IDX_W'(in_a);
                        cur_next   = IDX_W'(in_a);
                        x_next     = IDX_W'(in_a);
                        state_next = S_WALK;
                    end
                    else
                    begin
                        state_next = S_NEXT;
                    end
                end
            end
            S_WALK:
            begin
                if (rd_par == cur_reg)
                begin
                    root_next  = cur_reg;
                    rank_next  = rd_rank;
                    rd_addr    = x_reg;
                    cur_next   = x_reg;
                    state_next = S_COMP;
                end
                else
                begin
                    rd_addr  = rd_par;
                    cur_next = rd_par;
                end
            end
            S_COMP:
            begin
                if (cur_reg == root_reg)
                begin
                    if (!phase_reg)
                    begin
                        ra_next      = root_reg;
                        ra_rank_next = rank_reg;
                        ra_ok_next   = 1'b1;
                        ra_out_next  = ELEM_W'(root_reg);
                        state_next   = S_NEXT;
                    end
                    else
                    begin
                        rb_next      = root_reg;
                        rb_rank_next = rank_reg;
                        rb_ok_next   = 1'b1;
                        rb_out_next  = ELEM_W'(root_reg);
                        state_next   = S_LINK;
                    end
                end
                else
                begin
                    wr_en    = 1'b1;
                    wr_addr  = cur_reg;
                    wr_data  = {rd_rank, root_reg};
                    rd_addr  = rd_par;
                    cur_next = rd_par;
                end
            end
            S_NEXT:
            begin
                if (kind_reg == REQ_UNION)
                begin
                    rb_out_next = b_reg;
                    if (b_ok)
                    begin
                        rd_addr    = b_idx;
                        cur_next   = b_idx;
                        x_next     = b_idx;
                        phase_next = 1'b1;
                        state_next = S_WALK;
                    end
                    else
                    begin
                        state_next = S_LINK;
                    end
                end
                else
                begin
                    state_next = S_LINK;
                end
            end
            S_LINK:
            begin
                merged_next = do_link;
                nr_next     = ra_out_reg;
                state_next  = S_DONE;
                if (do_link)
                begin
                    wr_en = 1'b1;
                    if (ra_rank_reg < rb_rank_reg)
                    begin
                        wr_addr = ra_reg;
                        wr_data = {ra_rank_reg, rb_reg};
                        nr_next = rb_out_reg;
                    end
                    else
                    begin
                        wr_addr = rb_reg;
                        wr_data = {rb_rank_reg, ra_reg};
                        if (ra_rank_reg == rb_rank_reg)
                        begin
                            state_next = S_BUMP;
                        end
                    end
                end
            end
            S_BUMP:
            begin
                wr_en   = 1'b1;
                wr_addr = ra_reg;
                if (ra_rank_reg == RANK_MAX)
                begin
                    wr_data = {RANK_MAX, ra_reg};
                end
                else
                begin
                    wr_data = {ra_rank_reg + RANK_W'(1), ra_reg};
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign res_valid    = (state_reg == S_DONE);
    assign res.root_a   = ra_out_reg;
    assign res.root_b   = rb_out_reg;
    assign res.merged   = merged_reg;
    assign res.new_root = nr_reg;

    // A path rewrite never reads back the entry it is overwriting.
    a_comp_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COMP) && wr_en |-> wr_addr != rd_addr)
        else $error("path rewrite reads the entry it writes");

    a_merge_needs_roots: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) && merged_reg |-> ra_ok_reg && rb_ok_reg
            && (kind_reg == REQ_UNION) && (ra_reg != rb_reg))
        else $error("merge reported without two distinct valid roots");

    a_unmerged_root: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) && !merged_reg |-> nr_reg == ra_out_reg)
        else $error("new root differs from root of a without a merge");

    a_bump_after_tie: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BUMP) |-> $past(state_reg) == S_LINK
            && ra_rank_reg == rb_rank_reg)
        else $error("rank raised without a tied link");

    a_find_no_b: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) && (kind_reg == REQ_FIND) |-> rb_out_reg == '0 && !merged_reg)
        else $error("find request carries a second root or a merge");

endmodule

@@ rtl/core/union_find_engine.sv @@
`timescale 1ns / 1ps

// Disjoint-set engine over NUM_ELEMS elements with union by rank and full path
// compression. A find transaction (tuser = 0) returns the root of elem_a; a union
// transaction (tuser = 1) finds and compresses elem_a, then elem_b, and links the
// two roots. Each element's parent link and rank share one memory word behind one
// read port and one write port, and the registered read sets the pace: a find
// walks the path of elem_a to its root, then walks it again and points each node
// on it straight at the root. A union does the same for elem_a, then for elem_b,
// then links the two roots and, when a tie raises a rank, writes the raised rank.
// An index outside the store skips its walk and its rewrite. One transaction is in
// work at a time and no request is accepted meanwhile; the output register lets a
// new request enter while the previous result waits. After reset the memory is
// cleared in a pass over all NUM_ELEMS entries, during which no request is
// accepted.
module union_find_engine #(
    parameter int NUM_ELEMS = ufe_pkg::NUM_ELEMS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // elem_a [9:0], elem_b [19:10], zero pad
    input  logic        s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // root_a, root_b, merged, new_root, zero pad
);

    import ufe_pkg::*;

    localparam int IDX_W = $clog2(NUM_ELEMS);
    localparam int ENT_W = IDX_W + RANK_W;

    logic             res_valid;
    logic             res_ready;
    res_t             res;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [ENT_W-1:0] wr_data;
    logic [IDX_W-1:0] rd_addr;
    logic [ENT_W-1:0] rd_data;

    logic             out_valid_reg, out_valid_next;
    res_t             out_reg,       out_next;

    ufe_store #(
        .NUM_ELEMS (NUM_ELEMS)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ufe_seq #(
        .NUM_ELEMS (NUM_ELEMS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_kind   (s_axis_tuser),
        .in_a      (s_axis_tdata[ELEM_W-1:0]),
        .in_b      (s_axis_tdata[2*ELEM_W-1:ELEM_W]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_reg.new_root, out_reg.merged,
                            out_reg.root_b, out_reg.root_a};

endmodule

@@ tb/sv/union_find_checker.sv @@
`timescale 1ns / 1ps

module union_find_checker #(
    parameter int NUM_ELEMS = ufe_pkg::NUM_ELEMS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // elem_a [9:0], elem_b [19:10], zero pad
    input  logic        s_axis_tuser,   // req_type
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,   // root_a, root_b, merged, new_root, zero pad
    output int          mismatches,
    output int          waiting,
    output int          merges
);

    import ufe_pkg::*;

    logic [ELEM_W-1:0] parent_link [NUM_ELEMS];
    logic [RANK_W-1:0] tree_rank   [NUM_ELEMS];
    res_t              pending_results [$];

    task automatic report_mismatch(input string what);
        if (mismatches < 20)
            $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    // Walks to the root, then points every node on the path straight at it.
    function automatic int find_and_compress(input int elem);
        int top_node;
        int node;
        int nxt;
        int steps;
        if (elem >= NUM_ELEMS)
            return elem;
        top_node = elem;
        steps    = 0;
        while (int'(parent_link[top_node]) != top_node && steps < NUM_ELEMS)
        begin
            nxt = int'(parent_link[top_node]);
            if (nxt >= NUM_ELEMS)
                break;
            top_node = nxt;
            steps++;
        end
        node  = elem;
        steps = 0;
        while (node != top_node && steps < NUM_ELEMS)
        begin
            nxt               = int'(parent_link[node]);
            parent_link[node] = ELEM_W'(top_node);
            if (nxt >= NUM_ELEMS)
                break;
            node = nxt;
            steps++;
        end
        return top_node;
    endfunction

    function automatic res_t resolve_request(input logic kind, input int a, input int b);
        res_t r;
        int   ra;
        int   rb;
        ra         = find_and_compress(a);
        r.root_a   = ELEM_W'(ra);
        r.root_b   = '0;
        r.merged   = 1'b0;
        r.new_root = ELEM_W'(ra);
        if (kind == REQ_UNION)
        begin
            rb       = find_and_compress(b);
            r.root_b = ELEM_W'(rb);
            if (ra != rb && ra < NUM_ELEMS && rb < NUM_ELEMS)
            begin
                r.merged = 1'b1;
                if (tree_rank[ra] < tree_rank[rb])
                begin
                    parent_link[ra] = ELEM_W'(rb);
                    r.new_root      = ELEM_W'(rb);
                end
                else
                begin
                    if (tree_rank[ra] == tree_rank[rb] && tree_rank[ra] < RANK_MAX)
                        tree_rank[ra] = tree_rank[ra] + 1'b1;
                    parent_link[rb] = ELEM_W'(ra);
                end
            end
        end
        return r;
    endfunction

    task automatic compare_result(input res_t got, input res_t want);
        if (got.root_a !== want.root_a)
            report_mismatch($sformatf("root_a is %0d, expected %0d", got.root_a, want.root_a));
        if (got.root_b !== want.root_b)
            report_mismatch($sformatf("root_b is %0d, expected %0d", got.root_b, want.root_b));
        if (got.merged !== want.merged)
            report_mismatch($sformatf("merged is %0d, expected %0d", got.merged, want.merged));
        if (got.new_root !== want.new_root)
            report_mismatch($sformatf("new_root is %0d, expected %0d",
                                      got.new_root, want.new_root));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t expected_res;
        res_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ELEMS; i++)
            begin
                parent_link[i] = ELEM_W'(i);
                tree_rank[i]   = '0;
            end
            pending_results.delete();
            waiting <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_res = resolve_request(s_axis_tuser, int'(s_axis_tdata[9:0]),
                                               int'(s_axis_tdata[19:10]));
                pending_results.insert(pending_results.size(), expected_res);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = res_t'(m_axis_tdata[$bits(res_t)-1:0]);
                if (pending_results.size() == 0)
                    report_mismatch("result transaction with no request outstanding");
                else
                begin
                    expected_res = pending_results.pop_front();
                    if (expected_res.merged)
                        merges <= merges + 1;
                    compare_result(got, expected_res);
                end
            end
            waiting <= pending_results.size();
        end
    end

    final
    begin
        if (pending_results.size() != 0)
            $display("%0d results never arrived.", pending_results.size());
    end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    import ufe_pkg::*;

    localparam int NUM_ELEMS = NUM_ELEMS_DEF;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // elem_a [9:0], elem_b [19:10], zero pad
    logic        s_axis_tuser;   // req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // root_a, root_b, merged, new_root, zero pad

    int mismatches;
    int waiting;
    int merges;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_left;
    int finds_sent;
    int unions_sent;

    union_find_engine #(
        .NUM_ELEMS (NUM_ELEMS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    union_find_checker #(
        .NUM_ELEMS (NUM_ELEMS)
    ) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .mismatches    (mismatches),
        .waiting       (waiting),
        .merges        (merges)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("Timeout: the run did not complete.");
        $display("** union_find_engine: FAILED **");
        $finish;
    end

    // While a hold-off is pending, hold_left counts down and the output is kept stalled.
    initial
    begin
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic send_req(input logic kind, input int a, input int b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {4'b0000, ELEM_W'(b), ELEM_W'(a)};
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (kind == REQ_UNION)
            unions_sent++;
        else
            finds_sent++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (waiting != 0)
            @(posedge clk);
    endtask

    // Pairs roots level by level so the last element ends up levels links deep.
    task automatic build_tree(input int base, input int levels);
        for (int lvl = 0; lvl < levels; lvl++)
            for (int i = 0; i < (1 << levels); i += (2 << lvl))
                send_req(REQ_UNION, base + i, base + i + (1 << lvl));
    endtask

    task automatic send_random(input int count, input int span);
        int   base;
        int   a;
        int   b;
        logic kind;
        base = $urandom_range(0, NUM_ELEMS - span);
        for (int n = 0; n < count; n++)
        begin
            kind = ($urandom_range(0, 99) < 65) ? REQ_UNION : REQ_FIND;
            if ($urandom_range(0, 9) == 0)
            begin
                a = $urandom_range(0, 1023);
                b = $urandom_range(0, 1023);
            end
            else
            begin
                a = base + $urandom_range(0, span - 1);
                b = base + $urandom_range(0, span - 1);
            end
            send_req(kind, a, b);
        end
    endtask

    initial
    begin
        int levels;
        int base;
        int span_by_phase [4];
        span_by_phase  = '{16, 64, 256, 1024};
        rst_n          <= 1'b0;
        s_axis_tvalid  <= 1'b0;
        s_axis_tdata   <= '0;
        s_axis_tuser   <= REQ_FIND;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 0;
        finds_sent     = 0;
        unions_sent    = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        send_req(REQ_FIND, 0, 1023);
        send_req(REQ_FIND, 1023, 0);
        send_req(REQ_UNION, 0, 1023);
        send_req(REQ_UNION, 1023, 0);
        send_req(REQ_UNION, 7, 7);
        send_req(REQ_FIND, 1023, 1023);
        build_tree(16, 4);
        send_req(REQ_UNION, 0, 16);
        send_req(REQ_UNION, 31, 1023);
        send_req(REQ_UNION, 40, 16);
        send_req(REQ_UNION, 16, 41);
        drain_results();

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = (ph == 1) ? 60 : (ph == 3) ? 25 : 0;
            recv_stall_pct = (ph == 2) ? 60 : (ph == 3) ? 25 : 0;
            if (ph == 0)
                hold_left = 400;
            levels = $urandom_range(3, 5);
            base   = $urandom_range(0, NUM_ELEMS - (1 << levels));
            build_tree(base, levels);
            send_req(REQ_FIND, base + (1 << levels) - 1, $urandom_range(0, 1023));
            send_random(150 - (1 << levels), span_by_phase[ph]);
            drain_results();
        end

        repeat (200) @(posedge clk);
        $display("Ran %0d finds and %0d unions (%0d merges), including binomial trees,",
                 finds_sent, unions_sent, merges);
        $display("a long output stall, and idle or stall rates of 0, 25 and 60 percent.");
        if (mismatches == 0)
            $display("** union_find_engine: PASSED **");
        else
            $display("** union_find_engine: FAILED **");
        $finish;
    end

endmodule

@@ union_find_engine.f @@
rtl/core/ufe_pkg.sv
rtl/core/ufe_store.sv
rtl/core/ufe_seq.sv
rtl/core/union_find_engine.sv
tb/sv/union_find_checker.sv
tb/sv/tb_top.sv
